// File: rtl/srfm_pkg.sv
package srfm_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int MIN_FREE = 2;

	localparam logic       FUNC_ADD  = 1'b0;
	localparam logic       FUNC_TEST = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ORDER  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_TEST   = 2'd3;

	typedef struct packed {
		logic [63:0] low;
		logic [63:0] high;
		logic [31:0] flags;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] flags;
	} result_t;

endpackage

// File: rtl/sorted_range_flag_map_core.sv
// sorted range flag map: holds up to CAPACITY sorted, non-overlapping address
// ranges, each with a 32-bit flag word, in one entry RAM with a registered read.
// an add beat (func 0) appends at the top: the first add fills entry zero, an add
// starting at or below the top range's upper bound returns out of order, a
// contiguous add with equal flags extends the top range, otherwise a zero-flag
// pad range fills any gap and the new range follows; with fewer than two free
// entries the add returns full and nothing changes. a test beat (func 1) returns
// the flags of the range holding the address, or zero, with status 3.
// sequencing: one beat at a time. an add that writes a pad range writes the
// new range from a second state, since the RAM has one write port. a test whose
// address lies outside the stored span pushes its result in the accept cycle;
// otherwise each binary search probe is a RAM read state, then a compare state,
// after the accept cycle, and an empty interval seen when no probe hits ends
// the search with zero flags. the top entry is cached in flops so adds
// need no read. results pass through a two-deep output buffer, so one more beat
// is taken while a result stalls. adds and searches never overlap, so RAM
// accesses need no forwarding. there is no clearing pass after reset.
module sorted_range_flag_map_core
	import srfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic [31:0] range_flags,
	input  logic [63:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  add_status,
	output logic [31:0] found_flags
);

	// sequencer to RAM and sequencer to output buffer
	ram_req_t ram_req;
	entry_t   ram_rdata;
	logic     res_push;
	result_t  res_data;
	logic     res_free;
	result_t  out_res;

	srfm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.range_low   (range_low),
		.range_high  (range_high),
		.range_flags (range_flags),
		.address     (address),
		.res_free    (res_free),
		.push        (res_push),
		.push_res    (res_data),
		.req         (ram_req),
		.rdata       (ram_rdata)
	);

	// entry store: low, high and flags of each range in one word
	srfm_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// result beat buffer, output register plus one hold slot
	srfm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_res  (res_data),
		.free      (res_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign add_status  = out_res.status;
	assign found_flags = out_res.flags;

endmodule

// File: rtl/srfm_ram.sv
module srfm_ram
	import srfm_pkg::*;
(
	input  logic     clk,
	input  ram_req_t req,
	output entry_t   rdata
);

	entry_t mem [CAPACITY];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/srfm_obuf.sv
module srfm_obuf
	import srfm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_res,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_valid_q;
	logic    hold_valid_q;
	result_t out_q;
	result_t hold_q;
	logic    take;

	assign take = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (hold_valid_q) begin
			if (!out_valid_q || take) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				hold_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_valid_q) begin
			if (!out_valid_q || take) begin
				out_q <= hold_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_q <= push_res;
			end else begin
				hold_q <= push_res;
			end
		end
	end

	assign free      = !hold_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// File: rtl/srfm_seq.sv
module srfm_seq
	import srfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic [31:0] range_flags,
	input  logic [63:0] address,
	input  logic        res_free,
	output logic        push,
	output result_t     push_res,
	output ram_req_t    req,
	input  entry_t      rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_WR2  = 2'd3;

	localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(CAPACITY - MIN_FREE);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] last_q;
	logic             empty_q;
	entry_t           top_q;
	logic [63:0]      low0_q;
	logic [63:0]      addr_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hn_q;
	entry_t           wr2_q;
	logic [IDX_W-1:0] wr2_idx_q;

	logic             accept;
	logic [63:0]      next_low;
	logic             order_err;
	logic             extend;
	logic             full;
	logic             gap;
	logic             addr_miss;
	logic             hit;
	logic             below;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	entry_t           new_ent;
	entry_t           pad_ent;
	entry_t           ext_ent;

	assign in_ready  = (state_q == S_IDLE) && res_free;
	assign accept    = in_valid && in_ready;
	assign next_low  = top_q.high + 64'd1;
	assign order_err = range_low <= top_q.high;
	assign extend    = (range_low == next_low) && (range_flags == top_q.flags);
	assign full      = last_q >= FULL_IDX;
	assign gap       = range_low != next_low;
	assign addr_miss = empty_q || (address > top_q.high) || (address < low0_q);
	assign hit       = (addr_q >= rdata.low) && (addr_q <= rdata.high);
	assign below     = addr_q < rdata.low;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hn_q} - (CNT_W + 1)'(1);
	assign mid       = mid_sum[IDX_W:1];

	always_comb begin
		new_ent.low   = range_low;
		new_ent.high  = range_high;
		new_ent.flags = range_flags;
		pad_ent.low   = next_low;
		pad_ent.high  = range_low - 64'd1;
		pad_ent.flags = 32'd0;
		ext_ent.low   = top_q.low;
		ext_ent.high  = range_high;
		ext_ent.flags = top_q.flags;
	end

	always_comb begin
		req      = '0;
		push     = 1'b0;
		push_res = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FUNC_ADD) begin
						push = 1'b1;
						if (empty_q) begin
							push_res.status = ST_OK;
							req.we          = 1'b1;
							req.waddr       = '0;
							req.wdata       = new_ent;
						end else if (order_err) begin
							push_res.status = ST_ORDER;
						end else if (extend) begin
							push_res.status = ST_OK;
							req.we          = 1'b1;
							req.waddr       = last_q;
							req.wdata       = ext_ent;
						end else if (full) begin
							push_res.status = ST_FULL;
						end else begin
							push_res.status = ST_OK;
							req.we          = 1'b1;
							req.waddr       = last_q + IDX_W'(1);
							req.wdata       = gap ? pad_ent : new_ent;
						end
					end else if (addr_miss) begin
						push            = 1'b1;
						push_res.status = ST_TEST;
					end
				end
			end
			S_SRCH: begin
				if (lo_q < hn_q) begin
					req.re    = 1'b1;
					req.raddr = mid;
				end else begin
					push            = 1'b1;
					push_res.status = ST_TEST;
				end
			end
			S_CMP: begin
				if (hit) begin
					push            = 1'b1;
					push_res.status = ST_TEST;
					push_res.flags  = rdata.flags;
				end
			end
			S_WR2: begin
				req.we    = 1'b1;
				req.waddr = wr2_idx_q;
				req.wdata = wr2_q;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= '0;
			empty_q <= 1'b1;
			lo_q    <= '0;
			hn_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_ADD) begin
							if (empty_q) begin
								last_q  <= '0;
								empty_q <= 1'b0;
							end else if (!order_err && !extend && !full) begin
								if (gap) begin
									last_q  <= last_q + IDX_W'(2);
									state_q <= S_WR2;
								end else begin
									last_q <= last_q + IDX_W'(1);
								end
							end
						end else if (!addr_miss) begin
							lo_q    <= '0;
							hn_q    <= CNT_W'(last_q) + CNT_W'(1);
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					state_q <= (lo_q < hn_q) ? S_CMP : S_IDLE;
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_IDLE;
					end else begin
						if (below) begin
							hn_q <= CNT_W'(mid);
						end else begin
							lo_q <= CNT_W'(mid) + CNT_W'(1);
						end
						state_q <= S_SRCH;
					end
				end
				S_WR2: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// cached copy of the top entry and of entry zero's low bound, the pending second write and the test address
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_ADD)) begin
			if (empty_q) begin
				top_q  <= new_ent;
				low0_q <= range_low;
			end else if (!order_err && extend) begin
				top_q.high <= range_high;
			end else if (!order_err && !full) begin
				top_q     <= new_ent;
				wr2_q     <= new_ent;
				wr2_idx_q <= last_q + IDX_W'(2);
			end
		end
		if (accept && (func == FUNC_TEST)) begin
			addr_q <= address;
		end
	end

endmodule

// File: rtl/srfm_checker.sv
module srfm_checker
	import srfm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  add_status,
	input logic [31:0] found_flags
);

	// stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(add_status) && $stable(found_flags))
		else $error("result beat changed while stalled");

	// add results never carry flags
	a_add_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (add_status != ST_TEST) |-> found_flags == 32'd0)
		else $error("add result with nonzero flags");

	// taking a beat while the output stalls fills the buffer or starts a search
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !out_ready |=> !in_ready)
		else $error("input taken with no room for its result");

endmodule

bind sorted_range_flag_map_core srfm_checker u_srfm_checker (.*);

// File: tb/sorted_range_flag_map_core_tb.sv
module sorted_range_flag_map_core_tb
	import srfm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic        func        = FUNC_ADD;
	logic [63:0] range_low   = '0;
	logic [63:0] range_high  = '0;
	logic [31:0] range_flags = '0;
	logic [63:0] address     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  add_status;
	logic [31:0] found_flags;

	sorted_range_flag_map_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.range_low   (range_low),
		.range_high  (range_high),
		.range_flags (range_flags),
		.address     (address),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.add_status  (add_status),
		.found_flags (found_flags)
	);

	// shadow copy of the range table
	logic [63:0] map_low   [CAPACITY];
	logic [63:0] map_high  [CAPACITY];
	logic [31:0] map_flags [CAPACITY];
	int          map_top      = 0;
	bit          map_is_empty = 1'b1;

	result_t pending_status_flags [$];
	result_t head_result;
	int      mismatch_count = 0;

	// sender burst control, receiver hold-off request
	int burst_left    = 0;
	bit gaps_enabled  = 1'b1;
	int hold_off_left = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < CAPACITY; i++) begin
			map_low[i]   = '0;
			map_high[i]  = '0;
			map_flags[i] = '0;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// binary search over entries 0..map_top
	function automatic logic [31:0] lookup_flags(logic [63:0] a);
		int lo_i;
		int hi_i;
		int mid;
		if (map_is_empty)
			return '0;
		if (a > map_high[map_top] || a < map_low[0])
			return '0;
		lo_i = 0;
		hi_i = map_top;
		while (lo_i <= hi_i) begin
			mid = lo_i + (hi_i - lo_i) / 2;
			if (a >= map_low[mid] && a <= map_high[mid])
				return map_flags[mid];
			if (a < map_low[mid])
				hi_i = mid - 1;
			else
				lo_i = mid + 1;
		end
		return '0;
	endfunction

	// append at the top, returns the add status and updates the shadow table
	function automatic logic [1:0] apply_add(logic [63:0] lo, logic [63:0] hi,
			logic [31:0] fl);
		int          t;
		logic [63:0] nxt;
		t = map_top;
		if (map_is_empty) begin
			map_top      = 0;
			map_low[0]   = lo;
			map_high[0]  = hi;
			map_flags[0] = fl;
			map_is_empty = 1'b0;
			return ST_OK;
		end
		if (lo <= map_high[t])
			return ST_ORDER;
		nxt = map_high[t] + 64'd1;
		if (lo == nxt && map_flags[t] == fl) begin
			map_high[t] = hi;
			return ST_OK;
		end
		if (CAPACITY - t - 1 < MIN_FREE)
			return ST_FULL;
		if (lo != nxt) begin
			t++;
			map_low[t]   = nxt;
			map_high[t]  = lo - 64'd1;
			map_flags[t] = '0;
		end
		t++;
		map_low[t]   = lo;
		map_high[t]  = hi;
		map_flags[t] = fl;
		map_top      = t;
		return ST_OK;
	endfunction

	// drive one beat, wait for acceptance, queue its expected result
	task automatic send_beat(logic f, logic [63:0] lo, logic [63:0] hi, logic [31:0] fl,
			logic [63:0] a);
		int      gap;
		result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = 0;
			if (gaps_enabled && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		func        <= f;
		range_low   <= lo;
		range_high  <= hi;
		range_flags <= fl;
		address     <= a;
		// handshake signals are stable at the falling edge
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		if (f == FUNC_ADD) begin
			r.status = apply_add(lo, hi, fl);
			r.flags  = '0;
		end else begin
			r.status = ST_TEST;
			r.flags  = lookup_flags(a);
		end
		pending_status_flags.push_back(r);
		@(posedge clk);
	endtask

	task automatic add_beat(logic [63:0] lo, logic [63:0] hi, logic [31:0] fl);
		send_beat(FUNC_ADD, lo, hi, fl, rand64());
	endtask

	task automatic test_beat(logic [63:0] a);
		send_beat(FUNC_TEST, rand64(), rand64(), $urandom(), a);
	endtask

	task automatic note_mismatch(string why, result_t want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch (%s): expected status %0d flags %h, got status %0d flags %h",
				why, want.status, want.flags, add_status, found_flags);
	endtask

	// result checker
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_status_flags.size() == 0) begin
				note_mismatch("no result awaited", '0);
			end else begin
				head_result = pending_status_flags.pop_front();
				if (add_status !== head_result.status || found_flags !== head_result.flags)
					note_mismatch("field", head_result);
			end
		end
	end

	// receiver: segments of random stall patterns, plus a long hold-off on request
	initial begin : receiver
		int seg_left;
		int mode;
		int period;
		int phase;
		seg_left = 0;
		mode     = 0;
		period   = 2;
		phase    = 0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				out_ready <= 1'b0;
				hold_off_left--;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 80);
					mode     = $urandom_range(0, 3);
					period   = $urandom_range(2, 5);
				end
				seg_left--;
				phase++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (phase % period == 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic test_empty_map_lookup();
		test_beat(64'd0);
		test_beat('1);
		test_beat(64'h150);
	endtask

	task automatic test_first_add_and_bounds();
		add_beat(64'h100, 64'h1ff, 32'hffff_ffff);
		test_beat(64'hff);
		test_beat(64'h100);
		test_beat(64'h1ff);
		test_beat(64'h200);
	endtask

	task automatic test_out_of_order_add();
		// start equal to the top bound, and start below everything
		add_beat(64'h1ff, 64'h300, 32'hffff_ffff);
		add_beat(64'd0, 64'd0, 32'd0);
	endtask

	task automatic test_contiguous_extension();
		add_beat(64'h200, 64'h2ff, 32'hffff_ffff);
		test_beat(64'h2ff);
	endtask

	task automatic test_new_flags_no_pad();
		add_beat(64'h300, 64'h3ff, 32'h0000_0001);
		test_beat(64'h300);
	endtask

	task automatic test_gap_padding();
		add_beat(64'h1000, 64'h10ff, 32'h5a5a_a5a5);
		test_beat(64'h800);
		test_beat(64'h1000);
	endtask

	task automatic test_reversed_range();
		// low above high is stored as given
		add_beat(64'h3000, 64'h2000, 32'h5a5a_a5a5);
		test_beat(64'h2000);
		test_beat(64'h2800);
	endtask

	task automatic test_random_traffic(int n);
		int          kind;
		int          k;
		int          pick;
		logic [63:0] base;
		logic [63:0] lo;
		logic [63:0] span;
		logic [63:0] off;
		logic [31:0] fl;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 99);
			base = map_high[map_top];
			if (kind < 50) begin
				// probe at and around the edges of a stored range, inside it, or above the top
				k    = $urandom_range(0, map_top);
				pick = $urandom_range(0, 5);
				case (pick)
					0: test_beat(map_low[k] - 64'd1);
					1: test_beat(map_low[k]);
					2: test_beat(map_high[k]);
					3: test_beat(map_high[k] + 64'd1);
					4: begin
						span = map_high[k] - map_low[k];
						off  = 64'($urandom_range(0, 1023));
						if (off > span)
							off = span;
						test_beat(map_low[k] + off);
					end
					default: test_beat(base + 64'($urandom_range(1, 4096)));
				endcase
			end else if (kind < 60) begin
				test_beat(rand64());
			end else if (kind < 90) begin
				// well-formed append: extension, contiguous new flags, or gap
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					lo = base + 64'd1;
					fl = map_flags[map_top];
				end else if (pick < 6) begin
					lo = base + 64'd1;
					fl = $urandom();
				end else begin
					lo = base + 64'd2 + 64'($urandom_range(0, 4096));
					fl = $urandom();
				end
				add_beat(lo, lo + 64'($urandom_range(0, 2047)), fl);
			end else begin
				add_beat(rand64(), rand64(), $urandom());
			end
		end
	endtask

	task automatic test_output_backpressure();
		// receiver holds off while the sender keeps offering back to back
		gaps_enabled  = 1'b0;
		burst_left    = 0;
		hold_off_left = 200;
		for (int i = 0; i < 12; i++)
			test_beat(map_low[$urandom_range(0, map_top)]);
		gaps_enabled = 1'b1;
	endtask

	task automatic test_capacity_limit();
		logic [63:0] base;
		// contiguous new ranges until no two entries are free
		for (int i = 0; i < CAPACITY && CAPACITY - map_top - 1 >= MIN_FREE; i++) begin
			base = map_high[map_top] + 64'd1;
			add_beat(base, base + 64'h3f, ~map_flags[map_top]);
		end
		// full without padding, then full with a gap
		base = map_high[map_top] + 64'd1;
		add_beat(base, base + 64'h3f, ~map_flags[map_top]);
		add_beat(base + 64'h100, base + 64'h1ff, $urandom());
		// extension still succeeds when full
		add_beat(base, base + 64'h7f, map_flags[map_top]);
		test_beat(base + 64'h7f);
	endtask

	task automatic test_top_extremes();
		logic [63:0] base;
		base = map_high[map_top] + 64'd1;
		add_beat(base, '1, map_flags[map_top]);
		test_beat('1);
		test_beat('1 - 64'd1);
		test_beat(64'd0);
		add_beat('1, '1, '1);
	endtask

	initial begin : main_seq
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_map_lookup();
		test_first_add_and_bounds();
		test_out_of_order_add();
		test_contiguous_extension();
		test_new_flags_no_pad();
		test_gap_padding();
		test_reversed_range();
		test_random_traffic(260);
		test_output_backpressure();
		test_random_traffic(260);
		test_capacity_limit();
		test_top_extremes();

		in_valid <= 1'b0;
		while (pending_status_flags.size() != 0) @(posedge clk);
		// catch any stray trailing beat
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#400_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
